### design/cnlc_pkg.sv
package cnlc_pkg;

  localparam int unsigned NumW   = 63;
  localparam int unsigned DigitN = 19;
  localparam int unsigned BcdW   = 4 * DigitN;
  localparam int unsigned CntW   = $clog2(NumW);
  localparam int unsigned PosW   = $clog2(DigitN + 1);

  typedef enum logic [1:0] {
    KindInvalid = 2'd0,
    KindAmex    = 2'd1,
    KindMaster  = 2'd2,
    KindVisa    = 2'd3
  } card_kind_e;

  typedef struct packed {
    card_kind_e      kind;
    logic            ok;
    logic [PosW-1:0] total;
  } cnlc_result_t;

endpackage

### design/cnlc_bin2bcd.sv
module cnlc_bin2bcd
  import cnlc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [NumW-1:0] bin_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [BcdW-1:0] bcd_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StShift = 3'b010,
    StDone  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [BcdW-1:0] adj;

  function automatic logic digits_ok(logic [BcdW-1:0] v);
    logic r;
    r = 1'b1;
    for (int i = 0; i < DigitN; i++) begin
      if (v[4*i +: 4] > 4'd9) begin
        r = 1'b0;
      end
    end
    return r;
  endfunction

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < DigitN; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          bin_d   = bin_i;
          bcd_d   = '0;
          cnt_d   = CntW'(NumW - 1);
          state_d = StShift;
        end
      end
      StShift: begin
        bcd_d = {adj[BcdW-2:0], bin_q[NumW-1]};
        bin_d = {bin_q[NumW-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StDone);
  assign bcd_o       = bcd_q;

`ifndef ASSERT_OFF
  a_bcd_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> digits_ok(bcd_q))
    else $error("converted digit out of decimal range");

  a_shift_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift && cnt_q == '0) |=> (state_q == StDone))
    else $error("conversion did not finish after the last shift");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(bcd_o)))
    else $error("converted request changed while waiting");
`endif

endmodule

### design/cnlc_digit_scan.sv
module cnlc_digit_scan
  import cnlc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [BcdW-1:0] bcd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cnlc_result_t    res_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  localparam logic [PosW-1:0] LenShort = PosW'(13);
  localparam logic [PosW-1:0] LenAmex  = PosW'(15);
  localparam logic [PosW-1:0] LenLong  = PosW'(16);
  localparam logic [PosW-1:0] LastPos  = PosW'(DigitN - 1);

  state_e          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [BcdW-1:0] dig_q, dig_d;
  logic [3:0]      sum_q, sum_d;
  logic [PosW-1:0] total_q, total_d;
  logic [3:0]      lead_q, lead_d;
  logic [3:0]      next_q, next_d;
  logic [3:0]      prev_q, prev_d;
  logic [3:0]      cur, cur2, val;
  logic [4:0]      sum_add;
  card_kind_e      kind;

  assign cur     = dig_q[3:0];
  assign cur2    = {cur[2:0], 1'b0};
  assign val     = pos_q[0] ? ((cur >= 4'd5) ? cur2 - 4'd9 : cur2) : cur;
  assign sum_add = {1'b0, sum_q} + {1'b0, val};

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    dig_d   = dig_q;
    sum_d   = sum_q;
    total_d = total_q;
    lead_d  = lead_q;
    next_d  = next_q;
    prev_d  = prev_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          dig_d   = bcd_i;
          pos_d   = '0;
          sum_d   = '0;
          total_d = PosW'(1);
          lead_d  = '0;
          next_d  = '0;
          prev_d  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        dig_d  = {4'd0, dig_q[BcdW-1:4]};
        prev_d = cur;
        sum_d  = (sum_add >= 5'd10) ? 4'(sum_add - 5'd10) : sum_add[3:0];
        if (cur != 4'd0) begin
          total_d = pos_q + 1'b1;
          lead_d  = cur;
          next_d  = prev_q;
        end
        if (pos_q == LastPos) begin
          state_d = StDone;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      StDone: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    sum_q   <= sum_d;
    total_q <= total_d;
    lead_q  <= lead_d;
    next_q  <= next_d;
    prev_q  <= prev_d;
  end

  always_comb begin
    kind = KindInvalid;
    priority if (sum_q != 4'd0) begin
      kind = KindInvalid;
    end else if (total_q == LenAmex) begin
      if (lead_q == 4'd3 && (next_q == 4'd4 || next_q == 4'd7)) begin
        kind = KindAmex;
      end
    end else if (total_q == LenLong) begin
      if (lead_q == 4'd5 && next_q >= 4'd1 && next_q <= 4'd5) begin
        kind = KindMaster;
      end else if (lead_q == 4'd4) begin
        kind = KindVisa;
      end
    end else if (total_q == LenShort) begin
      if (lead_q == 4'd4) begin
        kind = KindVisa;
      end
    end else begin
      kind = KindInvalid;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StDone);
  assign res_o.kind  = kind;
  assign res_o.ok    = (sum_q == 4'd0);
  assign res_o.total = total_q;

`ifndef ASSERT_OFF
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_o.total >= PosW'(1) && res_o.total <= PosW'(DigitN)))
    else $error("digit count out of range");

  a_kind_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_o.kind != KindInvalid) |-> res_o.ok)
    else $error("card kind reported with failing checksum");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && pos_q == LastPos) |=> out_valid_o)
    else $error("scan did not finish after the top digit");
`endif

endmodule

### design/card_number_luhn_classify.sv
// Channel  Signals                                      Direction
// in       in_valid_i, in_ready_o, card_number_i        request in
// out      out_valid_o, out_ready_i, card_kind_o,       request out
//          checksum_ok_o, digit_total_o
//
// A request passes a bit-serial binary to decimal converter and then a digit scanner
// that handles one decimal digit per cycle; the converter can take the next request
// while the scanner still works on the last one.
// A stalled output holds the scanner, and then the converter, without loss.
// Reset returns both stages to idle; no memory needs clearing.
module card_number_luhn_classify
  import cnlc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [NumW-1:0] card_number_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      card_kind_o,
  output logic            checksum_ok_o,
  output logic [4:0]      digit_total_o
);

  logic            bcd_valid;
  logic            bcd_ready;
  logic [BcdW-1:0] bcd;
  cnlc_result_t    res;

  cnlc_bin2bcd u_bin2bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .bin_i       (card_number_i),
    .out_valid_o (bcd_valid),
    .out_ready_i (bcd_ready),
    .bcd_o       (bcd)
  );

  cnlc_digit_scan u_digit_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bcd_valid),
    .in_ready_o  (bcd_ready),
    .bcd_i       (bcd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign card_kind_o   = res.kind;
  assign checksum_ok_o = res.ok;
  assign digit_total_o = res.total;

endmodule
